[sv/dram_timing_constraint_checker_top_assert.svh]
// ----------------------------------------------------------------------------
// DRAM timing checker assertion macros
// Shared property forms for the top level checks.
// ----------------------------------------------------------------------------
`ifndef DRAM_TIMING_CONSTRAINT_CHECKER_TOP_ASSERT_SVH
`define DRAM_TIMING_CONSTRAINT_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define DTCC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTCC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/dtcc_pkg.sv]
// ----------------------------------------------------------------------------
// DRAM timing checker package
// Shared types, constants and small tables of the timing checker.
// ----------------------------------------------------------------------------
package dtcc_pkg;

   localparam int NUM_COMMANDS      = 16;
   localparam int TREE_LEVELS       = 4;
   localparam int MAX_FANOUT        = 4;
   localparam int SLOTS_PER_COMMAND = 8;
   localparam int MAX_WINDOW        = 4;
   localparam int NODE_COUNT        = 85;
   localparam int ROW_COUNT         = NODE_COUNT * NUM_COMMANDS;
   localparam int CONS_COUNT        = TREE_LEVELS * NUM_COMMANDS * SLOTS_PER_COMMAND;

   localparam int CMD_W  = 4;
   localparam int LVL_W  = 2;
   localparam int PATH_W = 6;
   localparam int NODE_W = 7;
   localparam int SLOT_W = 3;
   localparam int CLK_W  = 40;
   localparam int RDY_W  = 42;
   localparam int LAT_W  = 16;
   localparam int WIN_W  = 3;
   localparam int ROW_W  = NODE_W + CMD_W;
   localparam int CONS_W = LVL_W + CMD_W + SLOT_W;

   localparam logic signed [RDY_W-1:0] RDY_NONE = -42'sd1;
   localparam logic [2:0] ADDR_ALL = 3'b111;
   localparam logic [ROW_W-1:0] ROW_LAST = 11'(ROW_COUNT - 1);
   localparam logic [LVL_W-1:0] LEVEL_LEAF = 2'(TREE_LEVELS - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = 3'(SLOTS_PER_COMMAND - 1);
   localparam logic [2:0] FANOUT_MAX = 3'(MAX_FANOUT);
   localparam logic [WIN_W-1:0] WINDOW_MAX = 3'(MAX_WINDOW);

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_ISSUE = 2'd1;
   localparam logic [1:0] FUNC_CHECK = 2'd2;

   localparam logic [1:0] KIND_EMPTY   = 2'd0;
   localparam logic [1:0] KIND_SAME    = 2'd1;
   localparam logic [1:0] KIND_SIBLING = 2'd2;
   localparam logic [1:0] KIND_RSVD    = 2'd3;

   localparam logic [1:0] REG_ROOT_ID = 2'd0;
   localparam logic [1:0] REG_RANKS   = 2'd1;
   localparam logic [1:0] REG_GROUPS  = 2'd2;
   localparam logic [1:0] REG_BANKS   = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [CMD_W-1:0] target;
      logic [LAT_W-1:0] latency;
      logic [WIN_W-1:0] window;
   } slot_type;

   typedef struct packed {
      logic [1:0] root_id;
      logic [2:0] ranks;
      logic [2:0] groups;
      logic [2:0] banks;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic clr_wr;
      logic walk_init;
      logic walk_next;
      logic hist_rd;
      logic hist_wr;
      logic slot_init;
      logic slot_next;
      logic cons_rd;
      logic slot_rd;
      logic slot_wr;
      logic chk_rd;
      logic chk_eval;
      logic chk_fail_en;
      logic rsp_fire;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic node_visit;
      logic node_self;
      logic walk_last;
      logic slot_last;
      logic slot_act;
      logic chk_on;
      logic chk_fail;
   } ctrl_stat_type;

   function automatic logic [NODE_W-1:0] level_offset(input logic [LVL_W-1:0] lvl);
      logic [NODE_W-1:0] off;
      unique case (lvl)
         2'd0:    off = 7'd0;
         2'd1:    off = 7'd1;
         2'd2:    off = 7'd5;
         default: off = 7'd21;
      endcase
      return off;
   endfunction

   function automatic logic [PATH_W-1:0] level_last(input logic [LVL_W-1:0] lvl);
      logic [PATH_W-1:0] last;
      unique case (lvl)
         2'd0:    last = 6'd0;
         2'd1:    last = 6'd3;
         2'd2:    last = 6'd15;
         default: last = 6'd63;
      endcase
      return last;
   endfunction

   function automatic logic [2:0] fanout_sat(input logic [2:0] v);
      return (v > FANOUT_MAX) ? FANOUT_MAX : v;
   endfunction

endpackage

[sv/dram_timing_constraint_checker_top.sv]
// ----------------------------------------------------------------------------
// DRAM timing constraint checker, top level
// Tracks per-node command ready clocks over a channel/rank/group/bank tree.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low. After reset the block
// clears its memories with busy high. A load captures the item and then writes
// its constraint slot. An issue walks all 85 tree positions; an addressed node
// adds a history update, and every visited node steps through each of its 8
// constraint slots, reading the slot and, when it applies, reading and writing
// the ready clock memory. A check walks all 85 positions with an evaluation for
// each node on the checked path, and its result is shown on rsp_may_issue for
// one cycle with rsp_strobe high; the receiver cannot stall it.
`include "dram_timing_constraint_checker_top_assert.svh"

module dram_timing_constraint_checker_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_command,
   input  logic signed [2:0]  req_addr_channel,
   input  logic signed [2:0]  req_addr_rank,
   input  logic signed [2:0]  req_addr_group,
   input  logic signed [2:0]  req_addr_bank,
   input  logic [39:0]        req_clk_req,
   input  logic [4:0]         req_cons_index,
   input  logic [1:0]         req_cons_kind,
   input  logic [3:0]         req_cons_target,
   input  logic [15:0]        req_cons_latency,
   input  logic [2:0]         req_cons_window,
   output logic               rsp_strobe,
   output logic               rsp_may_issue,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   dtcc_pkg::cfg_type        cfg;
   dtcc_pkg::ctrl_cmd_type   cmd;
   dtcc_pkg::ctrl_stat_type  stat;
   logic                     check_take;

   dtcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtcc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .func  (req_func),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   dtcc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_addr_channel (req_addr_channel),
      .req_addr_rank    (req_addr_rank),
      .req_addr_group   (req_addr_group),
      .req_addr_bank    (req_addr_bank),
      .req_clk_req      (req_clk_req),
      .req_cons_index   (req_cons_index),
      .req_cons_kind    (req_cons_kind),
      .req_cons_target  (req_cons_target),
      .req_cons_latency (req_cons_latency),
      .req_cons_window  (req_cons_window),
      .rsp_strobe       (rsp_strobe),
      .rsp_may_issue    (rsp_may_issue)
   );

   assign check_take = start && !busy && (req_func == dtcc_pkg::FUNC_CHECK);

   `DTCC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "double strobe")
   `DTCC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "strobe while busy")
   `DTCC_ASSERT_NEXT(a_check_busy, clock, reset, check_take, busy, "check item not started")

endmodule

[sv/dtcc_csr.sv]
// ----------------------------------------------------------------------------
// DRAM timing checker register file
// APB-style configuration registers: root id and per-level fan-out.
// ----------------------------------------------------------------------------
module dtcc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output dtcc_pkg::cfg_type   cfg
);

   dtcc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            dtcc_pkg::REG_ROOT_ID: cfg_in.root_id = pwdata[1:0];
            dtcc_pkg::REG_RANKS:   cfg_in.ranks   = pwdata[2:0];
            dtcc_pkg::REG_GROUPS:  cfg_in.groups  = pwdata[2:0];
            default:               cfg_in.banks   = pwdata[2:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{root_id: 2'd0, ranks: 3'd4, groups: 3'd4, banks: 3'd4};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         dtcc_pkg::REG_ROOT_ID: prdata = {30'd0, cfg_ff.root_id};
         dtcc_pkg::REG_RANKS:   prdata = {29'd0, cfg_ff.ranks};
         dtcc_pkg::REG_GROUPS:  prdata = {29'd0, cfg_ff.groups};
         default:               prdata = {29'd0, cfg_ff.banks};
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

[sv/dtcc_ctrl.sv]
// ----------------------------------------------------------------------------
// DRAM timing checker controller
// Sequences memory clear, slot loads, issue tree walks and check walks.
// ----------------------------------------------------------------------------
module dtcc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                func,
   input  dtcc_pkg::ctrl_stat_type   stat,
   output dtcc_pkg::ctrl_cmd_type    cmd,
   output logic                      busy
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_LOAD     = 4'd2;
   localparam logic [3:0] S_NODE     = 4'd3;
   localparam logic [3:0] S_HIST     = 4'd4;
   localparam logic [3:0] S_SLOT_RD  = 4'd5;
   localparam logic [3:0] S_SLOT_TGT = 4'd6;
   localparam logic [3:0] S_SLOT_WR  = 4'd7;
   localparam logic [3:0] S_CHK      = 4'd8;
   localparam logic [3:0] S_CHK_EV   = 4'd9;
   localparam logic [3:0] S_RSP      = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               priority case (func)
                  dtcc_pkg::FUNC_LOAD: state_in = S_LOAD;
                  dtcc_pkg::FUNC_ISSUE: begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_NODE;
                  end
                  dtcc_pkg::FUNC_CHECK: begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_CHK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_NODE: begin
            priority if (!stat.node_visit) begin
               if (stat.walk_last) state_in = S_IDLE;
               else cmd.walk_next = 1'b1;
            end else if (stat.node_self) begin
               cmd.hist_rd = 1'b1;
               state_in    = S_HIST;
            end else begin
               cmd.slot_init = 1'b1;
               state_in      = S_SLOT_RD;
            end
         end
         S_HIST: begin
            cmd.hist_wr   = 1'b1;
            cmd.slot_init = 1'b1;
            state_in      = S_SLOT_RD;
         end
         S_SLOT_RD: begin
            cmd.cons_rd = 1'b1;
            state_in    = S_SLOT_TGT;
         end
         S_SLOT_TGT, S_SLOT_WR: begin
            if (state_ff == S_SLOT_TGT && stat.slot_act) begin
               cmd.slot_rd = 1'b1;
               state_in    = S_SLOT_WR;
            end else begin
               cmd.slot_wr = (state_ff == S_SLOT_WR);
               priority if (!stat.slot_last) begin
                  cmd.slot_next = 1'b1;
                  state_in      = S_SLOT_RD;
               end else if (stat.walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.walk_next = 1'b1;
                  state_in      = S_NODE;
               end
            end
         end
         S_CHK: begin
            if (stat.chk_on) begin
               cmd.chk_rd      = 1'b1;
               cmd.chk_fail_en = 1'b1;
               state_in        = S_CHK_EV;
            end else if (stat.walk_last) begin
               state_in = S_RSP;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         S_CHK_EV: begin
            cmd.chk_eval = 1'b1;
            if (stat.walk_last) begin
               state_in = S_RSP;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_CHK;
            end
         end
         S_RSP: begin
            cmd.rsp_fire = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[sv/dtcc_datapath.sv]
// ----------------------------------------------------------------------------
// DRAM timing checker datapath
// Ready clock, issue history and constraint memories, tree walk counters
// and the update / check arithmetic.
// ----------------------------------------------------------------------------
module dtcc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  dtcc_pkg::cfg_type         cfg,
   input  dtcc_pkg::ctrl_cmd_type    cmd,
   output dtcc_pkg::ctrl_stat_type   stat,
   input  logic [3:0]                req_command,
   input  logic [2:0]                req_addr_channel,
   input  logic [2:0]                req_addr_rank,
   input  logic [2:0]                req_addr_group,
   input  logic [2:0]                req_addr_bank,
   input  logic [39:0]               req_clk_req,
   input  logic [4:0]                req_cons_index,
   input  logic [1:0]                req_cons_kind,
   input  logic [3:0]                req_cons_target,
   input  logic [15:0]               req_cons_latency,
   input  logic [2:0]                req_cons_window,
   output logic                      rsp_strobe,
   output logic                      rsp_may_issue
);

   typedef logic [dtcc_pkg::MAX_WINDOW-1:0][dtcc_pkg::RDY_W-1:0] hist_row_type;

   logic signed [dtcc_pkg::RDY_W-1:0] rdy_mem [dtcc_pkg::ROW_COUNT];
   hist_row_type                      hist_mem [dtcc_pkg::ROW_COUNT];
   dtcc_pkg::slot_type                cons_mem [dtcc_pkg::CONS_COUNT];

   logic [dtcc_pkg::ROW_W-1:0]        clr_ff;
   logic [dtcc_pkg::CMD_W-1:0]        cmd_ff;
   logic [2:0]                        addr_ff [0:3];
   logic [dtcc_pkg::CLK_W-1:0]        clk_ff;
   logic [dtcc_pkg::CONS_W-1:0]       load_addr_ff;
   dtcc_pkg::slot_type                load_slot_ff;
   logic [dtcc_pkg::LVL_W-1:0]        level_ff;
   logic [dtcc_pkg::PATH_W-1:0]       path_ff;
   logic [dtcc_pkg::SLOT_W-1:0]       slot_ff;
   dtcc_pkg::slot_type                cons_q_ff;
   logic signed [dtcc_pkg::RDY_W-1:0] rdy_q_ff;
   hist_row_type                      hist_q_ff;
   hist_row_type                      hist_cur_ff;
   logic signed [dtcc_pkg::RDY_W-1:0] fut_ff, fut_in;
   logic                              ok_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_ok_ff;

   logic [1:0]                        dig [1:3];
   logic [2:0]                        cnt [0:3];
   logic [2:0]                        idv [0:3];
   logic [3:0]                        addressed;
   logic [dtcc_pkg::LVL_W-1:0]        lvl_nx;
   logic [dtcc_pkg::NODE_W-1:0]       node;
   logic [dtcc_pkg::ROW_W-1:0]        row_cmd;
   logic [dtcc_pkg::ROW_W-1:0]        row_tgt;
   logic [1:0]                        win_idx;
   logic signed [dtcc_pkg::RDY_W-1:0] past;
   logic signed [dtcc_pkg::RDY_W-1:0] clk_ext;
   hist_row_type                      hist_shift;
   logic                              visit;
   logic                              chk_on;
   logic                              chk_fail;
   logic                              slot_act;

   // tree position
   always_comb begin
      dig[1] = 2'd0;
      dig[2] = 2'd0;
      dig[3] = 2'd0;
      unique case (level_ff)
         2'd0: ;
         2'd1: dig[1] = path_ff[1:0];
         2'd2: begin
            dig[1] = path_ff[3:2];
            dig[2] = path_ff[1:0];
         end
         default: begin
            dig[1] = path_ff[5:4];
            dig[2] = path_ff[3:2];
            dig[3] = path_ff[1:0];
         end
      endcase
      cnt[0] = dtcc_pkg::fanout_sat(cfg.ranks);
      cnt[1] = dtcc_pkg::fanout_sat(cfg.groups);
      cnt[2] = dtcc_pkg::fanout_sat(cfg.banks);
      cnt[3] = 3'd0;
      idv[0] = {1'b0, cfg.root_id};
      idv[1] = {1'b0, dig[1]};
      idv[2] = {1'b0, dig[2]};
      idv[3] = {1'b0, dig[3]};
      for (int k = 0; k < 4; k++) begin
         addressed[k] = (addr_ff[k] == dtcc_pkg::ADDR_ALL) || (addr_ff[k] == idv[k]);
      end
      visit  = 1'b1;
      chk_on = 1'b1;
      for (int k = 1; k < 4; k++) begin
         if (k <= int'(level_ff)) begin
            if (!(idv[k] < cnt[k-1]) || !addressed[k-1]) visit = 1'b0;
            if (!(idv[k] < cnt[k-1]) || !addressed[k]) chk_on = 1'b0;
         end
      end
      lvl_nx   = level_ff + 2'd1;
      chk_fail = (level_ff != dtcc_pkg::LEVEL_LEAF) && (cnt[level_ff] != 3'd0) &&
                 (addr_ff[lvl_nx] != dtcc_pkg::ADDR_ALL) &&
                 (addr_ff[lvl_nx][2] || ({1'b0, addr_ff[lvl_nx][1:0]} >= cnt[level_ff]));
   end

   assign node    = dtcc_pkg::level_offset(level_ff) + {1'b0, path_ff};
   assign row_cmd = {node, cmd_ff};
   assign row_tgt = {node, cons_q_ff.target};
   assign clk_ext = $signed({2'b00, clk_ff});
   assign win_idx = cons_q_ff.window[1:0] - 2'd1;
   assign past    = $signed(hist_cur_ff[win_idx]);
   assign hist_shift = {hist_q_ff[dtcc_pkg::MAX_WINDOW-2:0], clk_ext};

   always_comb begin
      if (addressed[level_ff]) begin
         slot_act = (cons_q_ff.kind == dtcc_pkg::KIND_SAME) &&
                    (cons_q_ff.window != 3'd0) &&
                    (cons_q_ff.window <= dtcc_pkg::WINDOW_MAX) && !past[dtcc_pkg::RDY_W-1];
         fut_in   = past + $signed({26'd0, cons_q_ff.latency});
      end else begin
         slot_act = (cons_q_ff.kind == dtcc_pkg::KIND_SIBLING);
         fut_in   = clk_ext + $signed({26'd0, cons_q_ff.latency});
      end
   end

   assign stat.clr_last   = (clr_ff == dtcc_pkg::ROW_LAST);
   assign stat.node_visit = visit;
   assign stat.node_self  = addressed[level_ff];
   assign stat.walk_last  = (level_ff == dtcc_pkg::LEVEL_LEAF) &&
                            (path_ff == dtcc_pkg::level_last(level_ff));
   assign stat.slot_last  = (slot_ff == dtcc_pkg::SLOT_LAST);
   assign stat.slot_act   = slot_act;
   assign stat.chk_on     = chk_on;
   assign stat.chk_fail   = chk_fail;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         rdy_mem[clr_ff]  <= dtcc_pkg::RDY_NONE;
         hist_mem[clr_ff] <= {dtcc_pkg::MAX_WINDOW{dtcc_pkg::RDY_NONE}};
         if (clr_ff[dtcc_pkg::ROW_W-1:dtcc_pkg::CONS_W] == '0) begin
            cons_mem[clr_ff[dtcc_pkg::CONS_W-1:0]] <= '0;
         end
      end else begin
         if (cmd.load_wr) cons_mem[load_addr_ff] <= load_slot_ff;
         if (cmd.hist_wr) hist_mem[row_cmd] <= hist_shift;
         if (cmd.slot_wr && (fut_ff > rdy_q_ff)) rdy_mem[row_tgt] <= fut_ff;
      end
      if (cmd.cons_rd) cons_q_ff <= cons_mem[{level_ff, cmd_ff, slot_ff}];
      if (cmd.hist_rd) hist_q_ff <= hist_mem[row_cmd];
      if (cmd.slot_rd) rdy_q_ff <= rdy_mem[row_tgt];
      else if (cmd.chk_rd) rdy_q_ff <= rdy_mem[row_cmd];
   end

   // item capture and working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff       <= req_command;
         addr_ff[0]   <= req_addr_channel;
         addr_ff[1]   <= req_addr_rank;
         addr_ff[2]   <= req_addr_group;
         addr_ff[3]   <= req_addr_bank;
         clk_ff       <= req_clk_req;
         load_addr_ff <= {req_cons_index[4:3], req_command, req_cons_index[2:0]};
         load_slot_ff <= '{kind: (req_cons_kind == dtcc_pkg::KIND_RSVD) ?
                                 dtcc_pkg::KIND_EMPTY : req_cons_kind,
                           target: req_cons_target,
                           latency: req_cons_latency,
                           window: req_cons_window};
      end
      if (cmd.hist_wr) hist_cur_ff <= hist_shift;
      if (cmd.slot_rd) fut_ff <= fut_in;
      if (cmd.rsp_fire) rsp_ok_ff <= ok_ff;
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         level_ff     <= '0;
         path_ff      <= '0;
         slot_ff      <= '0;
         ok_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) clr_ff <= clr_ff + 11'd1;
         if (cmd.walk_init) begin
            level_ff <= '0;
            path_ff  <= '0;
            ok_ff    <= 1'b1;
         end else if (cmd.walk_next) begin
            if (path_ff == dtcc_pkg::level_last(level_ff)) begin
               level_ff <= level_ff + 2'd1;
               path_ff  <= '0;
            end else begin
               path_ff <= path_ff + 6'd1;
            end
         end
         if (cmd.chk_fail_en && chk_fail) ok_ff <= 1'b0;
         if (cmd.chk_eval && (rdy_q_ff != dtcc_pkg::RDY_NONE) && (clk_ext < rdy_q_ff)) begin
            ok_ff <= 1'b0;
         end
         if (cmd.slot_init) slot_ff <= '0;
         else if (cmd.slot_next) slot_ff <= slot_ff + 3'd1;
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_may_issue = rsp_ok_ff;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// DRAM timing constraint checker testbench
// Drives load, issue, check and unused-function items with random gaps, takes
// each check result as given or predicts it from a behavioral copy of the node
// tree, and compares every result.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int WDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 2600;

   typedef struct {
      logic [1:0]  f;
      logic [3:0]  cmd;
      int          ch, rk, gp, bk;
      logic [39:0] clk;
      logic [4:0]  idx;
      logic [1:0]  kind;
      logic [3:0]  tgt;
      logic [15:0] lat;
      logic [2:0]  win;
      bit          typed;
      bit          ok;
   } item_type;

   typedef struct {
      logic [1:0] kind;
      logic [3:0] tgt;
      logic [15:0] lat;
      logic [2:0] win;
   } rule_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy;
   logic [1:0] req_func = 0;
   logic [3:0] req_command = 0;
   logic signed [2:0] req_addr_channel = 0, req_addr_rank = 0;
   logic signed [2:0] req_addr_group = 0, req_addr_bank = 0;
   logic [39:0] req_clk_req = 0;
   logic [4:0] req_cons_index = 0;
   logic [1:0] req_cons_kind = 0;
   logic [3:0] req_cons_target = 0;
   logic [15:0] req_cons_latency = 0;
   logic [2:0] req_cons_window = 0;
   logic rsp_strobe, rsp_may_issue;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [3:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   dram_timing_constraint_checker_top dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // behavioral state
   longint   ready_at[dtcc_pkg::NODE_COUNT][dtcc_pkg::NUM_COMMANDS];
   longint   issued_at[dtcc_pkg::NODE_COUNT][dtcc_pkg::NUM_COMMANDS][dtcc_pkg::MAX_WINDOW];
   rule_type rules[dtcc_pkg::TREE_LEVELS][dtcc_pkg::NUM_COMMANDS][dtcc_pkg::SLOTS_PER_COMMAND];
   int       cfg_root, cfg_fan[3];

   bit     ok_queue[$];
   int     errs = 0;
   int     idle_cycles = 0;
   longint clk_now = 0;

   task automatic report(input string msg);
      $display("tb_top: mismatch at %0t: %s", $realtime, msg);
      errs++;
   endtask

   function automatic int node_of(int lvl, int path);
      int offs[4] = '{0, 1, 5, 21};
      return offs[lvl] + path;
   endfunction

   function automatic int fanout(int lvl);
      if (lvl >= 3) return 0;
      return (cfg_fan[lvl] > dtcc_pkg::MAX_FANOUT) ? dtcc_pkg::MAX_FANOUT : cfg_fan[lvl];
   endfunction

   function automatic void raise_ready(int nd, int tgt, longint t);
      if (t > ready_at[nd][tgt]) ready_at[nd][tgt] = t;
   endfunction

   function automatic void walk_issue(int lvl, int path, int id, int cmd,
                                      int a[4], longint clk);
      int nd;
      longint past;
      rule_type r;
      nd = node_of(lvl, path);
      if (id != a[lvl] && a[lvl] != -1) begin
         for (int s = 0; s < dtcc_pkg::SLOTS_PER_COMMAND; s++) begin
            r = rules[lvl][cmd][s];
            if (r.kind == dtcc_pkg::KIND_SIBLING) raise_ready(nd, r.tgt, clk + r.lat);
         end
         return;
      end
      for (int w = dtcc_pkg::MAX_WINDOW - 1; w > 0; w--)
         issued_at[nd][cmd][w] = issued_at[nd][cmd][w-1];
      issued_at[nd][cmd][0] = clk;
      for (int s = 0; s < dtcc_pkg::SLOTS_PER_COMMAND; s++) begin
         r = rules[lvl][cmd][s];
         if (r.kind != dtcc_pkg::KIND_SAME || r.win == 0 || r.win > dtcc_pkg::MAX_WINDOW)
            continue;
         past = issued_at[nd][cmd][r.win - 1];
         if (past < 0) continue;
         raise_ready(nd, r.tgt, past + r.lat);
      end
      for (int c = 0; c < fanout(lvl); c++)
         walk_issue(lvl + 1, path * dtcc_pkg::MAX_FANOUT + c, c, cmd, a, clk);
   endfunction

   function automatic bit may_issue(int lvl, int path, int cmd, int a[4], longint clk);
      longint r;
      int n, child;
      bit ok;
      r = ready_at[node_of(lvl, path)][cmd];
      if (r != -1 && clk < r) return 0;
      n = fanout(lvl);
      if (n == 0) return 1;
      child = a[lvl + 1];
      if (child == -1) begin
         ok = 1;
         for (int c = 0; c < n && ok; c++)
            ok = may_issue(lvl + 1, path * dtcc_pkg::MAX_FANOUT + c, cmd, a, clk);
         return ok;
      end
      if (child < 0 || child >= n) return 0;
      return may_issue(lvl + 1, path * dtcc_pkg::MAX_FANOUT + child, cmd, a, clk);
   endfunction

   // applies an accepted item; returns 1 when a result is due
   function automatic bit apply_item(input item_type it, output bit ok);
      int a[4];
      a = '{it.ch, it.rk, it.gp, it.bk};
      ok = 0;
      case (it.f)
         dtcc_pkg::FUNC_LOAD: begin
            rules[it.idx / dtcc_pkg::SLOTS_PER_COMMAND][it.cmd]
                 [it.idx % dtcc_pkg::SLOTS_PER_COMMAND] =
               '{(it.kind == dtcc_pkg::KIND_RSVD) ? dtcc_pkg::KIND_EMPTY : it.kind,
                 it.tgt, it.lat, it.win};
            return 0;
         end
         dtcc_pkg::FUNC_ISSUE: begin
            walk_issue(0, 0, cfg_root, it.cmd, a, longint'(it.clk));
            return 0;
         end
         dtcc_pkg::FUNC_CHECK: begin
            ok = may_issue(0, 0, it.cmd, a, longint'(it.clk));
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   task automatic send_item(input item_type it);
      bit due, ok;
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1;
      req_func         <= it.f;
      req_command      <= it.cmd;
      req_addr_channel <= 3'(it.ch);
      req_addr_rank    <= 3'(it.rk);
      req_addr_group   <= 3'(it.gp);
      req_addr_bank    <= 3'(it.bk);
      req_clk_req      <= it.clk;
      req_cons_index   <= it.idx;
      req_cons_kind    <= it.kind;
      req_cons_target  <= it.tgt;
      req_cons_latency <= it.lat;
      req_cons_window  <= it.win;
      @(posedge clock);
      while (busy) @(posedge clock);
      due = apply_item(it, ok);
      if (due) ok_queue.insert(ok_queue.size(), it.typed ? it.ok : ok);
   endtask

   task automatic csr_access(input logic [1:0] reg_idx, input bit wr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1;
      penable <= 0;
      pwrite  <= wr;
      paddr   <= 4'(reg_idx) << 2;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      rdata = prdata;
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic set_config(input int root, input int rk, input int gp, input int bk);
      logic [31:0] rd;
      int vals[4];
      vals = '{root, rk, gp, bk};
      start <= 0;
      @(posedge clock);
      while (ok_queue.size() > 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_access(dtcc_pkg::REG_ROOT_ID, 1, 32'(root), rd);
      csr_access(dtcc_pkg::REG_RANKS, 1, 32'(rk), rd);
      csr_access(dtcc_pkg::REG_GROUPS, 1, 32'(gp), rd);
      csr_access(dtcc_pkg::REG_BANKS, 1, 32'(bk), rd);
      for (int i = 0; i < 4; i++) begin
         csr_access(2'(i), 0, 32'd0, rd);
         if (rd[2:0] != 3'(vals[i]))
            report($sformatf("csr %0d read %0h, wrote %0h", i, rd, vals[i]));
      end
      cfg_root = root & 3;
      cfg_fan  = '{rk & 7, gp & 7, bk & 7};
   endtask

   function automatic int rand_addr();
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) return int'($urandom_range(0, 2)) - 4;
      if (r < 7) return -1;
      return $urandom_range(0, 3);
   endfunction

   function automatic item_type rand_item();
      item_type it;
      int r;
      it = '{default: 0};
      r = $urandom_range(0, 99);
      it.f = (r < 25) ? dtcc_pkg::FUNC_LOAD : (r < 52) ? dtcc_pkg::FUNC_ISSUE :
             (r < 96) ? dtcc_pkg::FUNC_CHECK : FUNC_NONE;
      it.cmd = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      it.ch = rand_addr();
      it.rk = rand_addr();
      it.gp = rand_addr();
      it.bk = rand_addr();
      it.idx  = 5'($urandom);
      it.kind = 2'($urandom);
      it.tgt  = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
      it.lat  = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 300)) : 16'($urandom);
      it.win  = 3'($urandom);
      clk_now += $urandom_range(0, 120);
      if (it.f == dtcc_pkg::FUNC_CHECK) begin
         if ($urandom_range(0, 29) == 0) it.clk = {8'($urandom), 32'($urandom)};
         else it.clk = 40'(clk_now + $urandom_range(0, 400));
      end else begin
         it.clk = ($urandom_range(0, 49) == 0) ? {8'($urandom), 32'($urandom)}
                                             : 40'(clk_now);
      end
      return it;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (ok_queue.size() == 0) report("result with none expected");
         else if (rsp_may_issue !== ok_queue[0]) begin
            report($sformatf("may_issue %b, expected %b", rsp_may_issue, ok_queue[0]));
            void'(ok_queue.pop_front());
         end else void'(ok_queue.pop_front());
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   item_type plan[20];
   int    phases[8][4] = '{'{3, 1, 1, 1}, '{1, 7, 7, 7}, '{2, 0, 0, 0}, '{0, 2, 3, 1},
                           '{3, 4, 0, 2}, '{1, 1, 2, 0}, '{2, 3, 1, 4}, '{0, 4, 4, 4}};

   initial begin
      item_type z;
      for (int n = 0; n < dtcc_pkg::NODE_COUNT; n++)
         for (int c = 0; c < dtcc_pkg::NUM_COMMANDS; c++) begin
            ready_at[n][c] = -1;
            for (int w = 0; w < dtcc_pkg::MAX_WINDOW; w++) issued_at[n][c][w] = -1;
         end
      for (int l = 0; l < dtcc_pkg::TREE_LEVELS; l++)
         for (int c = 0; c < dtcc_pkg::NUM_COMMANDS; c++)
            for (int s = 0; s < dtcc_pkg::SLOTS_PER_COMMAND; s++)
               rules[l][c][s] = '{dtcc_pkg::KIND_EMPTY, 0, 0, 0};
      cfg_root = 0;
      cfg_fan  = '{4, 4, 4};

      z = '{default: 0};
      foreach (plan[i]) plan[i] = z;
      // after reset every command is free everywhere
      plan[0] = '{dtcc_pkg::FUNC_CHECK, 0, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0, 1, 1};
      // negative rank address other than all names no child
      plan[1] = '{dtcc_pkg::FUNC_CHECK, 0, 0, -2, -1, -1, 5, 0, 0, 0, 0, 0, 1, 0};
      plan[2] = '{FUNC_NONE, 1, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0};
      plan[3] = '{dtcc_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 0,
                  dtcc_pkg::KIND_SAME, 2, 100, 1, 0, 0};
      plan[4] = '{dtcc_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 8,
                  dtcc_pkg::KIND_SIBLING, 3, 16'hffff, 0, 0, 0};
      plan[5] = '{dtcc_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 1,
                  dtcc_pkg::KIND_RSVD, 4, 50, 1, 0, 0};
      plan[6] = '{dtcc_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 2,
                  dtcc_pkg::KIND_SAME, 5, 50, 0, 0, 0};
      plan[7] = '{dtcc_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 3,
                  dtcc_pkg::KIND_SAME, 6, 50, 7, 0, 0};
      plan[8] = '{dtcc_pkg::FUNC_LOAD, 15, 0, 0, 0, 0, 0, 31,
                  dtcc_pkg::KIND_SAME, 15, 16'hffff, 4, 0, 0};
      plan[9] = '{dtcc_pkg::FUNC_LOAD, 1, 0, 0, 0, 0, 0, 16,
                  dtcc_pkg::KIND_SAME, 1, 500, 2, 0, 0};
      plan[10] = '{dtcc_pkg::FUNC_ISSUE, 1, 0, 1, -1, -1, 1000, 0, 0, 0, 0, 0, 0, 0};
      plan[11] = '{dtcc_pkg::FUNC_ISSUE, 1, 0, 1, 2, -1, 1200, 0, 0, 0, 0, 0, 0, 0};
      plan[12] = '{dtcc_pkg::FUNC_CHECK, 2, -1, -1, -1, -1, 1050, 0, 0, 0, 0, 0, 0, 0};
      plan[13] = '{dtcc_pkg::FUNC_CHECK, 2, 0, -1, -1, -1, 1300, 0, 0, 0, 0, 0, 0, 0};
      plan[14] = '{dtcc_pkg::FUNC_CHECK, 3, 0, 0, -1, -1, 2000, 0, 0, 0, 0, 0, 0, 0};
      plan[15] = '{dtcc_pkg::FUNC_CHECK, 1, 0, 1, 2, 3, 1600, 0, 0, 0, 0, 0, 0, 0};
      plan[16] = '{dtcc_pkg::FUNC_ISSUE, 15, -1, -4, -1, 3, 40'hff_ffff_ffff,
                   0, 0, 0, 0, 0, 0, 0};
      plan[17] = '{dtcc_pkg::FUNC_ISSUE, 15, 3, -1, -1, -1, 40'hff_ffff_ffff,
                   0, 0, 0, 0, 0, 0, 0};
      plan[18] = '{dtcc_pkg::FUNC_CHECK, 15, -1, -1, -1, -1, 40'hff_ffff_ffff,
                   0, 0, 0, 0, 0, 0, 0};
      plan[19] = '{dtcc_pkg::FUNC_CHECK, 15, 0, 3, 3, 3, 2000, 0, 0, 0, 0, 0, 0, 0};

      repeat (10) @(posedge clock);
      reset <= 0;
      foreach (plan[i]) send_item(plan[i]);
      clk_now = 3000;
      for (int i = 0; i < 100; i++) send_item(rand_item());
      foreach (phases[p]) begin
         set_config(phases[p][0], phases[p][1], phases[p][2], phases[p][3]);
         for (int i = 0; i < 160; i++) send_item(rand_item());
      end

      start <= 0;
      @(posedge clock);
      while (ok_queue.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errs == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule
